### rtl/mbgu_pkg.sv
// ---------------------------------------------------------------------------
// mbgu_pkg
// Shared constants and types of the masked bilinear grid upscaler.
// ---------------------------------------------------------------------------
package mbgu_pkg;

    localparam int MAX_SRC_WIDTH  = 512;
    localparam int MAX_SRC_HEIGHT = 512;
    localparam int FRAC_BITS      = 16;
    localparam int POS_BITS       = 17;

    localparam int X_BITS    = $clog2(MAX_SRC_WIDTH);
    localparam int Y_BITS    = $clog2(MAX_SRC_HEIGHT);
    localparam int BANK_AW   = X_BITS + Y_BITS - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int NUM_BANKS = 4;

    localparam int DIM_BITS   = 10;
    localparam int SCALE_BITS = 24;
    localparam int P_BITS     = 17 + SCALE_BITS + 1;
    localparam int Q_BITS     = P_BITS - POS_BITS;
    localparam int W_BITS     = 2 * FRAC_BITS + 1;
    localparam int PROD_BITS  = W_BITS + 7;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int NUM_BITS   = SUM_BITS + 1;
    localparam int DEN_BITS   = W_BITS + 1;
    localparam int QUO_BITS   = 7;
    localparam int DIV_BITS   = DEN_BITS + QUO_BITS - 1;
    localparam int MIN_WEIGHT = 1 << (2 * FRAC_BITS - 20);

    // configuration register indexes
    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_INV_SCALE  = 2'd2;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               en;
        logic [1:0]         bank;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         data;
    } store_wr_t;

    typedef struct packed {
        logic                valid;
        logic                none;
        logic [NUM_BITS-1:0] rem;
        logic [DIV_BITS-1:0] dsr;
        logic [QUO_BITS-1:0] quo;
    } div_t;

endpackage

### rtl/mbgu_locate.sv
// ---------------------------------------------------------------------------
// mbgu_locate
// Turns one scaled source position into two clamped neighbour indexes
// and the interpolation fraction along that axis.
// ---------------------------------------------------------------------------
module mbgu_locate
(
    input  logic [mbgu_pkg::P_BITS-1:0]    pos,
    input  logic [mbgu_pkg::DIM_BITS-1:0]  dim_raw,
    input  logic [mbgu_pkg::DIM_BITS-1:0]  dim_max,
    output logic [mbgu_pkg::DIM_BITS-2:0]  idx0,
    output logic [mbgu_pkg::DIM_BITS-2:0]  idx1,
    output logic [mbgu_pkg::FRAC_BITS-1:0] frac
);
    import mbgu_pkg::*;

    logic [DIM_BITS-1:0] dim;
    logic [Q_BITS-1:0]   q;
    logic [Q_BITS-1:0]   qm1;
    logic [Q_BITS-1:0]   lim;

    // grid size clamped to the store (zero taken as one), then neighbours clamped to the grid
    always_comb
    begin
        if (dim_raw == '0)
            dim = DIM_BITS'(1);
        else if (dim_raw > dim_max)
            dim = dim_max;
        else
            dim = dim_raw;
        lim = Q_BITS'(dim) - Q_BITS'(1);
        q   = pos[P_BITS-1:POS_BITS];
        qm1 = q - Q_BITS'(1);
        idx1 = (q > lim) ? lim[DIM_BITS-2:0] : q[DIM_BITS-2:0];
        if (q == '0)
            idx0 = '0;
        else if (qm1 > lim)
            idx0 = lim[DIM_BITS-2:0];
        else
            idx0 = qm1[DIM_BITS-2:0];
        frac = pos[POS_BITS-1:POS_BITS-FRAC_BITS];
    end

endmodule

### rtl/mbgu_grid_store.sv
// ---------------------------------------------------------------------------
// mbgu_grid_store
// Source grid in four banks split by row and column parity, so the four
// neighbours of a position are read together in the same cycle.
// ---------------------------------------------------------------------------
module mbgu_grid_store
(
    input  logic                       clk,
    input  mbgu_pkg::store_wr_t        wr,
    input  logic [mbgu_pkg::BANK_AW-1:0] rd_addr [mbgu_pkg::NUM_BANKS],
    output logic [7:0]                 rd_data [mbgu_pkg::NUM_BANKS]
);
    import mbgu_pkg::*;

    for (genvar b = 0; b < NUM_BANKS; b++)
    begin : g_bank
        logic [7:0] mem [BANK_DEPTH];

        // one write and one registered read per bank
        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.bank == 2'(b)))
                mem[wr.addr] <= wr.data;
            rd_data[b] <= mem[rd_addr[b]];
        end
    end

endmodule

### rtl/mbgu_div_step.sv
// ---------------------------------------------------------------------------
// mbgu_div_step
// One registered restoring division step, one quotient bit per stage.
// ---------------------------------------------------------------------------
module mbgu_div_step
(
    input  logic           clk,
    input  logic           rst_n,
    input  mbgu_pkg::div_t din,
    output mbgu_pkg::div_t dout
);
    import mbgu_pkg::*;

    logic valid_reg;
    logic valid_next;
    div_t data_reg;
    div_t data_next;
    logic ge;

    // compare, subtract, shift the divisor down
    always_comb
    begin
        ge = din.rem >= NUM_BITS'(din.dsr);
        valid_next = din.valid;
        data_next.valid = din.valid;
        data_next.none  = din.none;
        data_next.rem   = ge ? (din.rem - NUM_BITS'(din.dsr)) : din.rem;
        data_next.dsr   = din.dsr >> 1;
        data_next.quo   = {din.quo[QUO_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dout = data_reg;
        dout.valid = valid_reg;
    end

endmodule

### rtl/masked_bilinear_grid_upscale.sv
// ---------------------------------------------------------------------------
// masked_bilinear_grid_upscale
// Bilinear occupancy grid resampler that skips unknown source cells.
// ---------------------------------------------------------------------------
// One item is taken every clock; busy is always low. A query returns its
// result through the pipeline: input register, position multiply, clamping,
// banked grid read with corner weights, masked products, weight sums, seven
// restoring division steps and the output register. Loads write the grid at
// the read stage, so a query started after a load always sees it. result_valid
// is high for one cycle and the receiver cannot hold it off.
// ---------------------------------------------------------------------------
module masked_bilinear_grid_upscale
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [15:0]       col,
    input  logic [15:0]       row,
    input  logic signed [7:0] cell_value,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [23:0]       cfg_data,
    output logic              result_valid,
    output logic signed [7:0] result_value
);
    import mbgu_pkg::*;

    localparam int LATENCY = 14;
    localparam int XI = DIM_BITS - 1;

    // configuration
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [SCALE_BITS-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(512);
            height_reg <= DIM_BITS'(512);
            scale_reg  <= SCALE_BITS'(65536);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_SRC_HEIGHT: height_reg <= cfg_data[DIM_BITS-1:0];
                REG_INV_SCALE:  scale_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits of the front stages
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;
    logic o_valid_reg;
    div_t div_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            o_valid_reg <= div_out.valid;
        end
    end

    // stage a: input beat
    logic        a_mode_reg;
    logic [15:0] a_col_reg, a_row_reg;
    logic [7:0]  a_val_reg;

    always_ff @(posedge clk)
    begin
        a_mode_reg <= mode;
        a_col_reg  <= col;
        a_row_reg  <= row;
        a_val_reg  <= cell_value;
    end

    // stage b: doubled source positions
    logic              b_mode_reg;
    logic [15:0]       b_col_reg, b_row_reg;
    logic [7:0]        b_val_reg;
    logic [P_BITS-1:0] b_px_reg, b_py_reg;

    always_ff @(posedge clk)
    begin
        b_mode_reg <= a_mode_reg;
        b_col_reg  <= a_col_reg;
        b_row_reg  <= a_row_reg;
        b_val_reg  <= a_val_reg;
        b_px_reg   <= P_BITS'({a_col_reg, 1'b1}) * P_BITS'(scale_reg)
                      + P_BITS'(1 << 16);
        b_py_reg   <= P_BITS'({a_row_reg, 1'b1}) * P_BITS'(scale_reg)
                      + P_BITS'(1 << 16);
    end

    // stage c: clamped neighbours and fractions
    logic [XI-1:0]        x0, x1, y0, y1;
    logic [FRAC_BITS-1:0] fx, fy;

    mbgu_locate u_loc_x
    (
        .pos     (b_px_reg),
        .dim_raw (width_reg),
        .dim_max (DIM_BITS'(MAX_SRC_WIDTH)),
        .idx0    (x0),
        .idx1    (x1),
        .frac    (fx)
    );

    mbgu_locate u_loc_y
    (
        .pos     (b_py_reg),
        .dim_raw (height_reg),
        .dim_max (DIM_BITS'(MAX_SRC_HEIGHT)),
        .idx0    (y0),
        .idx1    (y1),
        .frac    (fy)
    );

    logic                 c_mode_reg;
    logic [15:0]          c_col_reg, c_row_reg;
    logic [7:0]           c_val_reg;
    logic [XI-1:0]        c_x0_reg, c_x1_reg, c_y0_reg, c_y1_reg;
    logic [FRAC_BITS-1:0] c_fx_reg, c_fy_reg;

    always_ff @(posedge clk)
    begin
        c_mode_reg <= b_mode_reg;
        c_col_reg  <= b_col_reg;
        c_row_reg  <= b_row_reg;
        c_val_reg  <= b_val_reg;
        c_x0_reg   <= x0;
        c_x1_reg   <= x1;
        c_y0_reg   <= y0;
        c_y1_reg   <= y1;
        c_fx_reg   <= fx;
        c_fy_reg   <= fy;
    end

    // stage d: grid access and corner weights
    store_wr_t          wr;
    logic [BANK_AW-1:0] rd_addr [NUM_BANKS];
    logic [7:0]         rd_data [NUM_BANKS];
    logic [X_BITS-1:0]  xsel [2];
    logic [Y_BITS-1:0]  ysel [2];

    always_comb
    begin
        wr.en   = c_valid_reg && (c_mode_reg == MODE_LOAD)
                  && (c_col_reg < 16'(MAX_SRC_WIDTH))
                  && (c_row_reg < 16'(MAX_SRC_HEIGHT));
        wr.bank = {c_row_reg[0], c_col_reg[0]};
        wr.addr = {c_row_reg[Y_BITS-1:1], c_col_reg[X_BITS-1:1]};
        wr.data = c_val_reg;
        for (int p = 0; p < 2; p++)
        begin
            xsel[p] = (c_x0_reg[0] == p[0]) ? c_x0_reg[X_BITS-1:0] : c_x1_reg[X_BITS-1:0];
            ysel[p] = (c_y0_reg[0] == p[0]) ? c_y0_reg[Y_BITS-1:0] : c_y1_reg[Y_BITS-1:0];
        end
        for (int b = 0; b < NUM_BANKS; b++)
            rd_addr[b] = {ysel[b / 2][Y_BITS-1:1], xsel[b % 2][X_BITS-1:1]};
    end

    mbgu_grid_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [FRAC_BITS:0] onex, oney, wxe, wye;
    logic [W_BITS-1:0]  d_cw_reg [4];
    logic [1:0]         d_bk_reg [4];
    logic               d_mode_reg;

    always_comb
    begin
        wxe  = {1'b0, c_fx_reg};
        wye  = {1'b0, c_fy_reg};
        onex = (FRAC_BITS+1)'(1 << FRAC_BITS) - wxe;
        oney = (FRAC_BITS+1)'(1 << FRAC_BITS) - wye;
    end

    always_ff @(posedge clk)
    begin
        d_mode_reg  <= c_mode_reg;
        d_cw_reg[0] <= W_BITS'(onex * oney);
        d_cw_reg[1] <= W_BITS'(wxe * oney);
        d_cw_reg[2] <= W_BITS'(onex * wye);
        d_cw_reg[3] <= W_BITS'(wxe * wye);
        d_bk_reg[0] <= {c_y0_reg[0], c_x0_reg[0]};
        d_bk_reg[1] <= {c_y0_reg[0], c_x1_reg[0]};
        d_bk_reg[2] <= {c_y1_reg[0], c_x0_reg[0]};
        d_bk_reg[3] <= {c_y1_reg[0], c_x1_reg[0]};
    end

    // stage e: mask unknown cells, weight the known ones
    logic                 e_mode_reg;
    logic [PROD_BITS-1:0] e_prod_reg [4];
    logic [W_BITS-1:0]    e_wt_reg [4];
    logic [7:0]           nv [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            nv[k] = rd_data[d_bk_reg[k]];
    end

    always_ff @(posedge clk)
    begin
        e_mode_reg <= d_mode_reg;
        for (int k = 0; k < 4; k++)
        begin
            e_prod_reg[k] <= nv[k][7] ? '0
                             : PROD_BITS'(PROD_BITS'(nv[k][6:0]) * PROD_BITS'(d_cw_reg[k]));
            e_wt_reg[k]   <= nv[k][7] ? '0 : d_cw_reg[k];
        end
    end

    // stage f: sums and divider operands
    logic [SUM_BITS-1:0]  sum;
    logic [DEN_BITS-1:0]  wsum;
    logic                 f_mode_reg;
    logic                 f_none_reg;
    logic [NUM_BITS-1:0]  f_num_reg;
    logic [DEN_BITS-1:0]  f_den_reg;

    always_comb
    begin
        sum  = SUM_BITS'(e_prod_reg[0]) + SUM_BITS'(e_prod_reg[1])
             + SUM_BITS'(e_prod_reg[2]) + SUM_BITS'(e_prod_reg[3]);
        wsum = DEN_BITS'(e_wt_reg[0]) + DEN_BITS'(e_wt_reg[1])
             + DEN_BITS'(e_wt_reg[2]) + DEN_BITS'(e_wt_reg[3]);
    end

    always_ff @(posedge clk)
    begin
        f_mode_reg <= e_mode_reg;
        f_none_reg <= wsum < DEN_BITS'(MIN_WEIGHT);
        f_num_reg  <= {sum, 1'b0} + NUM_BITS'(wsum);
        f_den_reg  <= {wsum[DEN_BITS-2:0], 1'b0};
    end

    // divider chain, one quotient bit per stage
    div_t chain [QUO_BITS+1];

    always_comb
    begin
        chain[0].valid = f_valid_reg && (f_mode_reg == MODE_QUERY);
        chain[0].none  = f_none_reg;
        chain[0].rem   = f_num_reg;
        chain[0].dsr   = DIV_BITS'(f_den_reg) << (QUO_BITS - 1);
        chain[0].quo   = '0;
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        mbgu_div_step u_step
        (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    assign div_out = chain[QUO_BITS];

    // output beat
    logic [7:0] o_val_reg;

    always_ff @(posedge clk)
    begin
        o_val_reg <= div_out.none ? 8'hFF : {1'b0, div_out.quo};
    end

    assign result_valid = o_valid_reg;
    assign result_value = o_val_reg;

    // every query gives one result beat, loads give none
    a_query_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && mode == MODE_QUERY) |-> ##LATENCY result_valid)
        else $error("query result missing");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (!start || mode == MODE_LOAD) |-> ##LATENCY !result_valid)
        else $error("result beat without query");

    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_value == -8'sd1 || result_value[7] == 1'b0))
        else $error("result out of range");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked bilinear grid upscaler: loads source
// cells, queries destination cells under several grid sizes and scales, and
// compares every result with an in-bench bilinear predictor.
// ---------------------------------------------------------------------------
module testbench;
    import mbgu_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY     = 14;
    localparam int CYCLE_LIMIT = 400000;
    localparam int GRID_CELLS  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

    typedef struct {
        logic              mode;
        logic [15:0]       col;
        logic [15:0]       row;
        logic signed [7:0] value;
        bit                typed;
        logic signed [7:0] want;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              mode;
    logic [15:0]       col;
    logic [15:0]       row;
    logic signed [7:0] cell_value;
    logic              cfg_write;
    logic [1:0]        cfg_index;
    logic [23:0]       cfg_data;
    logic              result_valid;
    logic signed [7:0] result_value;

    // predictor state
    logic signed [7:0] grid_copy [0:GRID_CELLS-1];
    bit                grid_known [0:GRID_CELLS-1];
    logic [9:0]        width_reg;
    logic [9:0]        height_reg;
    logic [23:0]       scale_reg;

    logic signed [7:0] pending_values [$];
    stim_row_t         directed_rows [$];
    int                mismatches;
    int                cycles;
    int                queries_sent;
    int                loads_sent;
    int                results_seen;

    masked_bilinear_grid_upscale i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .col          (col),
        .row          (row),
        .cell_value   (cell_value),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_value (result_value)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // effective grid dimension
    function automatic int eff_dim(logic [9:0] v, int maxv);
        if (v == 0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    // base index and 16-bit fraction of one destination coordinate
    function automatic void place_coord(logic [15:0] d, output longint base,
                                        output longint unsigned frac);
        longint unsigned p;
        p = (2 * longint'(d) + 1) * longint'(scale_reg) + (1 << 17) - (1 << 16);
        base = longint'(p >> 17) - 1;
        frac = (p & 64'h1FFFF) >> 1;
    endfunction

    function automatic int clamp_to(longint v, int n);
        if (v < 0)
            return 0;
        if (v > n - 1)
            return n - 1;
        return int'(v);
    endfunction

    // the four neighbours and their weights of a destination cell
    function automatic void neighbours(logic [15:0] c, logic [15:0] r,
                                       output int xs [2], output int ys [2],
                                       output longint unsigned cw [4]);
        longint bx, by;
        longint unsigned fx, fy;
        longint unsigned one;
        place_coord(c, bx, fx);
        place_coord(r, by, fy);
        xs[0] = clamp_to(bx, eff_dim(width_reg, MAX_SRC_WIDTH));
        xs[1] = clamp_to(bx + 1, eff_dim(width_reg, MAX_SRC_WIDTH));
        ys[0] = clamp_to(by, eff_dim(height_reg, MAX_SRC_HEIGHT));
        ys[1] = clamp_to(by + 1, eff_dim(height_reg, MAX_SRC_HEIGHT));
        one = 64'd1 << FRAC_BITS;
        cw[0] = (one - fx) * (one - fy);
        cw[1] = fx * (one - fy);
        cw[2] = (one - fx) * fy;
        cw[3] = fx * fy;
    endfunction

    function automatic bit neighbours_loaded(logic [15:0] c, logic [15:0] r);
        int xs [2];
        int ys [2];
        longint unsigned cw [4];
        neighbours(c, r, xs, ys, cw);
        for (int k = 0; k < 4; k++)
        begin
            if (!grid_known[ys[k >> 1] * MAX_SRC_WIDTH + xs[k & 1]])
                return 0;
        end
        return 1;
    endfunction

    // masked bilinear blend, rounded half up
    function automatic logic signed [7:0] blend_cell(logic [15:0] c, logic [15:0] r);
        int xs [2];
        int ys [2];
        longint unsigned cw [4];
        longint unsigned total, wsum, q;
        logic signed [7:0] v;
        total = 0;
        wsum = 0;
        neighbours(c, r, xs, ys, cw);
        for (int k = 0; k < 4; k++)
        begin
            v = grid_copy[ys[k >> 1] * MAX_SRC_WIDTH + xs[k & 1]];
            if (v >= 0)
            begin
                total += longint'(v) * cw[k];
                wsum += cw[k];
            end
        end
        if (wsum < MIN_WEIGHT)
            return -8'sd1;
        q = (2 * total + wsum) / (2 * wsum);
        if (q > 127)
            q = 127;
        return 8'(q);
    endfunction

    // update the grid copy on a load, expected value on a query
    function automatic void take_beat(logic m, logic [15:0] c, logic [15:0] r,
                                      logic signed [7:0] v);
        if (m == MODE_LOAD)
        begin
            loads_sent++;
            if (c < MAX_SRC_WIDTH && r < MAX_SRC_HEIGHT)
            begin
                grid_copy[r * MAX_SRC_WIDTH + c] = v;
                grid_known[r * MAX_SRC_WIDTH + c] = 1;
            end
        end
        else
        begin
            queries_sent++;
            pending_values = {pending_values, blend_cell(c, r)};
        end
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one beat and hold it until accepted
    task automatic send_beat(logic m, logic [15:0] c, logic [15:0] r,
                             logic signed [7:0] v, bit typed, logic signed [7:0] want,
                             bit no_gaps);
        int gap;
        start <= 1'b1;
        mode <= m;
        col <= c;
        row <= r;
        cell_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        take_beat(m, c, r, v);
        if (typed && m == MODE_QUERY)
            pending_values[$] = want;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // register write while idle
    task automatic write_reg(logic [1:0] idx, logic [23:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  width_reg = data[9:0];
            REG_SRC_HEIGHT: height_reg = data[9:0];
            REG_INV_SCALE:  scale_reg = data;
            default: ;
        endcase
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [7:0] rand_value();
        if ($urandom_range(0, 4) == 0)
            return -8'sd128 + 8'($urandom_range(0, 127));
        return 8'($urandom_range(0, 127));
    endfunction

    // fill the low corner and the far corner of the active grid
    task automatic load_regions();
        int w, h, rw, rh;
        w = eff_dim(width_reg, MAX_SRC_WIDTH);
        h = eff_dim(height_reg, MAX_SRC_HEIGHT);
        rw = (w < 8) ? w : 8;
        rh = (h < 8) ? h : 8;
        for (int y = 0; y < rh; y++)
            for (int x = 0; x < rw; x++)
                send_beat(MODE_LOAD, 16'(x), 16'(y), rand_value(), 0, 0, $urandom_range(0, 1));
        for (int y = h - rh; y < h; y++)
            for (int x = w - rw; x < w; x++)
                send_beat(MODE_LOAD, 16'(x), 16'(y), rand_value(), 0, 0, $urandom_range(0, 1));
    endtask

    // random mix of queries and loads
    task automatic random_beats(int count);
        logic [15:0] c, r;
        bit found, calm;
        calm = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
            begin
                found = 0;
                for (int t = 0; t < 30 && !found; t++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        c = 16'($urandom);
                        r = 16'($urandom);
                    end
                    else
                    begin
                        c = 16'($urandom_range(0, 12));
                        r = 16'($urandom_range(0, 12));
                    end
                    found = neighbours_loaded(c, r);
                end
                if (found)
                    send_beat(MODE_QUERY, c, r, 8'($urandom), 0, 0, calm);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                // outside the store, ignored
                c = 16'($urandom);
                r = 16'($urandom);
                if ($urandom_range(0, 1))
                    c[15:9] = 7'h7F;
                else
                    r[15:9] = 7'h7F;
                send_beat(MODE_LOAD, c, r, 8'($urandom), 0, 0, calm);
            end
            else
            begin
                c = 16'($urandom_range(0, 15));
                r = 16'($urandom_range(0, 15));
                send_beat(MODE_LOAD, c, r, rand_value(), 0, 0, calm);
            end
        end
    endtask

    task automatic run_phase(logic [9:0] w, logic [9:0] h, logic [23:0] s, int count);
        write_reg(REG_SRC_WIDTH, {14'd0, w});
        write_reg(REG_SRC_HEIGHT, {14'd0, h});
        write_reg(REG_INV_SCALE, s);
        load_regions();
        random_beats(count);
        drain();
    endtask

    function automatic void add_row(logic m, logic [15:0] c, logic [15:0] r,
                                    logic signed [7:0] v, bit typed, logic signed [7:0] want);
        stim_row_t s;
        s.mode = m;
        s.col = c;
        s.row = r;
        s.value = v;
        s.typed = typed;
        s.want = want;
        directed_rows = {directed_rows, s};
    endfunction

    // result check
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_seen++;
            if (pending_values.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: result_value=%0d", result_value);
            end
            else
            begin
                if (result_value !== pending_values[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result_value mismatch: expected %0d, got %0d",
                                 pending_values[0], result_value);
                end
                void'(pending_values.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        queries_sent = 0;
        loads_sent = 0;
        results_seen = 0;
        width_reg = 10'd512;
        height_reg = 10'd512;
        scale_reg = 24'd65536;
        for (int i = 0; i < GRID_CELLS; i++)
        begin
            grid_copy[i] = 0;
            grid_known[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_LOAD;
        col = '0;
        row = '0;
        cell_value = '0;
        cfg_write = 1'b0;
        cfg_index = REG_SRC_WIDTH;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, unit scale, so each query lands on one cell
        add_row(MODE_LOAD, 0, 0, 127, 0, 0);
        add_row(MODE_LOAD, 1, 0, -128, 0, 0);
        add_row(MODE_LOAD, 2, 0, 0, 0, 0);
        add_row(MODE_LOAD, 0, 1, 0, 0, 0);
        add_row(MODE_LOAD, 1, 1, 5, 0, 0);
        add_row(MODE_LOAD, 2, 1, -1, 0, 0);
        add_row(MODE_LOAD, 0, 2, 64, 0, 0);
        add_row(MODE_LOAD, 1, 2, 1, 0, 0);
        add_row(MODE_LOAD, 2, 2, 100, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 1, 127);
        add_row(MODE_QUERY, 1, 0, 0, 1, -1);
        add_row(MODE_QUERY, 0, 1, -128, 1, 0);
        add_row(MODE_QUERY, 1, 1, 127, 1, 5);
        add_row(MODE_LOAD, 16'hFFFF, 16'hFFFF, -128, 0, 0);
        add_row(MODE_LOAD, 512, 0, 33, 0, 0);
        add_row(MODE_LOAD, 0, 512, 33, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 1, 127);
        add_row(MODE_LOAD, 0, 0, -1, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 1, -1);
        add_row(MODE_LOAD, 0, 0, 0, 0, 0);
        add_row(MODE_QUERY, 0, 0, 0, 1, 0);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].mode, directed_rows[i].col, directed_rows[i].row,
                      directed_rows[i].value, directed_rows[i].typed,
                      directed_rows[i].want, 0);
        drain();

        // random: reset settings first, then a sweep of sizes and scales
        load_regions();
        random_beats(80);
        drain();
        write_reg(REG_UNUSED, 24'hFFFFFF);
        run_phase(10'd4, 10'd3, 24'd16384, 80);
        run_phase(10'd0, 10'd0, 24'd0, 60);
        run_phase(10'd1023, 10'd1023, 24'hFFFFFF, 80);
        run_phase(10'd1, 10'd512, 24'd1, 60);
        run_phase(10'd16, 10'd9, 24'($urandom_range(20000, 200000)), 80);
        run_phase(10'($urandom_range(1, 20)), 10'($urandom_range(1, 20)),
                  24'($urandom_range(8000, 150000)), 80);
        run_phase(10'($urandom_range(1, 600)), 10'($urandom_range(1, 600)),
                  24'($urandom), 80);

        if (pending_values.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_values.size());
        end
        $display("covered %0d loads and %0d queries, %0d results compared",
                 loads_sent, queries_sent, results_seen);
        $display("grid sizes from one cell to clamped maximum, scales from zero to full range");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/mbgu_pkg.sv
rtl/mbgu_locate.sv
rtl/mbgu_grid_store.sv
rtl/mbgu_div_step.sv
rtl/masked_bilinear_grid_upscale.sv
verif/testbench.sv
